>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/kftr_pkg.sv
// ---------------------------------------------------------------------------
// kftr_pkg
// Shared types and constants for the key tally and rank block.
// ---------------------------------------------------------------------------
package kftr_pkg;

  localparam int ENTRIES    = 32;
  localparam int COUNT_BITS = 32;
  localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_BITS  = $clog2(ENTRIES + 1);
  localparam int KEY_BITS   = 64;

  localparam logic [2:0] ST_COUNTED = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_RANK    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic [1:0] RS_ZERO = 2'd0;
  localparam logic [1:0] RS_ONE  = 2'd1;
  localparam logic [1:0] RS_MEM  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic                 load_in;    // capture input key
    logic                 rd_en;      // read entry at rd_addr
    logic [IDX_BITS-1:0]  rd_addr;
    logic                 ld_a;       // latch read data into A
    logic                 ld_b;       // latch read data into B
    logic                 wr_a;       // write A to wr_addr
    logic                 wr_b;       // write B to wr_addr
    logic                 wr_new;     // write key with count 1
    logic                 wr_inc;     // write incremented B
    logic [IDX_BITS-1:0]  wr_addr;
    logic                 res_ld;     // load result register
    logic [2:0]           res_status;
    logic [5:0]           res_rank;
    logic [1:0]           res_src;    // count source
    logic                 res_key_in; // key from input rather than B
    logic                 res_last;
  } kftr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic key_eq;   // B key equals captured key
    logic a_lt_b;   // count A below count B
  } kftr_sts_t;

endpackage

>>> rtl/core/kftr_datapath.sv
// ---------------------------------------------------------------------------
// kftr_datapath
// Key/count memories, swap registers and result register.
// ---------------------------------------------------------------------------
module kftr_datapath (
  input  logic                 clk,
  input  logic [63:0]          key_in,
  input  kftr_pkg::kftr_cmd_t  cmd,
  output kftr_pkg::kftr_sts_t  sts,
  output logic [2:0]           r_status,
  output logic [5:0]           r_rank,
  output logic [31:0]          r_count,
  output logic [63:0]          r_key,
  output logic                 r_last
);

  logic [63:0]                   key_mem [kftr_pkg::ENTRIES];
  logic [kftr_pkg::COUNT_BITS-1:0] cnt_mem [kftr_pkg::ENTRIES];
  logic [63:0]                   rd_key;
  logic [kftr_pkg::COUNT_BITS-1:0] rd_cnt;
  logic [63:0]                   key_q, a_key, b_key;
  logic [kftr_pkg::COUNT_BITS-1:0] a_cnt, b_cnt, inc_cnt, wr_cnt, src_cnt;
  logic [63:0]                   wr_key;
  logic [31:0]                   sat_cnt;

  assign inc_cnt = (b_cnt == {kftr_pkg::COUNT_BITS{1'b1}}) ? b_cnt : b_cnt + 1'b1;

  always_comb begin
    wr_key = b_key;
    wr_cnt = b_cnt;
    if (cmd.wr_a) begin
      wr_key = a_key;
      wr_cnt = a_cnt;
    end else if (cmd.wr_new) begin
      wr_key = key_q;
      wr_cnt = kftr_pkg::COUNT_BITS'(1);
    end else if (cmd.wr_inc) begin
      wr_cnt = inc_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_a || cmd.wr_b || cmd.wr_new || cmd.wr_inc) begin
      key_mem[cmd.wr_addr] <= wr_key;
      cnt_mem[cmd.wr_addr] <= wr_cnt;
    end
    if (cmd.rd_en) begin
      rd_key <= key_mem[cmd.rd_addr];
      rd_cnt <= cnt_mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) key_q <= key_in;
    if (cmd.ld_a) begin
      a_key <= rd_key;
      a_cnt <= rd_cnt;
    end
    if (cmd.ld_b) begin
      b_key <= rd_key;
      b_cnt <= rd_cnt;
    end
  end

  assign sts.key_eq = (b_key == key_q);
  assign sts.a_lt_b = (a_cnt < b_cnt);

  always_comb begin
    case (cmd.res_src)
      kftr_pkg::RS_ZERO: src_cnt = '0;
      kftr_pkg::RS_ONE:  src_cnt = kftr_pkg::COUNT_BITS'(1);
      kftr_pkg::RS_MEM:  src_cnt = cmd.wr_inc ? inc_cnt : b_cnt;
      default:           src_cnt = '0;
    endcase
  end

  generate
    if (kftr_pkg::COUNT_BITS > 32) begin : g_wide
      assign sat_cnt = (|src_cnt[kftr_pkg::COUNT_BITS-1:32]) ? 32'hFFFF_FFFF
                                                             : src_cnt[31:0];
    end else begin : g_narrow
      assign sat_cnt = 32'(src_cnt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      r_status <= cmd.res_status;
      r_rank   <= cmd.res_rank;
      r_count  <= sat_cnt;
      r_key    <= (cmd.res_status == kftr_pkg::ST_EMPTY) ? 64'd0 :
                  cmd.res_key_in ? key_q : b_key;
      r_last   <= cmd.res_last;
    end
  end

endmodule

>>> rtl/core/kftr_ctrl.sv
// ---------------------------------------------------------------------------
// kftr_ctrl
// Sequencer: linear search, insertion sort by adjacent swaps, readout.
// ---------------------------------------------------------------------------
module kftr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 action,
  input  logic                 out_busy,
  input  logic                 out_take,
  input  kftr_pkg::kftr_sts_t  sts,
  output kftr_pkg::kftr_cmd_t  cmd,
  output logic                 idle,
  output logic                 out_set
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRD   = 4'd1;  // search: issue read
  localparam logic [3:0] S_SLAT  = 4'd2;  // search: read data arrives
  localparam logic [3:0] S_SCMP  = 4'd3;  // search: compare
  localparam logic [3:0] S_WAIT  = 4'd4;  // wait for result to leave
  localparam logic [3:0] S_ORD   = 4'd5;  // sort: read j-1
  localparam logic [3:0] S_OLA   = 4'd6;  // sort: latch A, read j
  localparam logic [3:0] S_OLB   = 4'd7;  // sort: latch B
  localparam logic [3:0] S_OCMP  = 4'd8;  // sort: compare / swap
  localparam logic [3:0] S_OSW2  = 4'd9;  // sort: second half of swap
  localparam logic [3:0] S_RRD   = 4'd10; // report: read
  localparam logic [3:0] S_RLAT  = 4'd11;
  localparam logic [3:0] S_RLB   = 4'd12;
  localparam logic [3:0] S_ROUT  = 4'd13;

  localparam int IB = kftr_pkg::IDX_BITS;
  localparam int UB = kftr_pkg::USED_BITS;

  logic [3:0]    state, state_next;
  logic [UB-1:0] used, used_next;
  logic [UB-1:0] i, i_next, j, j_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      used  <= used_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    used_next  = used;
    i_next     = i;
    j_next     = j;
    cmd        = '0;
    out_set    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          i_next      = '0;
          if (!action) begin
            state_next = S_SRD;
          end else if (used <= UB'(1)) begin
            i_next     = '0;
            state_next = S_RRD;
          end else begin
            i_next     = UB'(1);
            j_next     = UB'(1);
            state_next = S_ORD;
          end
        end
      end
      S_SRD: begin
        if (i == used) begin
          if (!out_busy || out_take) begin
            cmd.res_ld     = 1'b1;
            cmd.res_key_in = 1'b1;
            cmd.res_last   = 1'b1;
            out_set        = 1'b1;
            if (used == UB'(kftr_pkg::ENTRIES)) begin
              cmd.res_status = kftr_pkg::ST_DROPPED;
              cmd.res_src    = kftr_pkg::RS_ZERO;
            end else begin
              cmd.res_status = kftr_pkg::ST_NEW;
              cmd.res_src    = kftr_pkg::RS_ONE;
              cmd.wr_new     = 1'b1;
              cmd.wr_addr    = i[IB-1:0];
              used_next      = used + 1'b1;
            end
            state_next = S_IDLE;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = i[IB-1:0];
          state_next  = S_SLAT;
        end
      end
      S_SLAT: begin
        cmd.ld_b   = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (sts.key_eq) begin
          if (!out_busy || out_take) begin
            cmd.wr_inc     = 1'b1;
            cmd.wr_addr    = i[IB-1:0];
            cmd.res_ld     = 1'b1;
            cmd.res_status = kftr_pkg::ST_COUNTED;
            cmd.res_src    = kftr_pkg::RS_MEM;
            cmd.res_key_in = 1'b1;
            cmd.res_last   = 1'b1;
            out_set        = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          i_next     = i + 1'b1;
          state_next = S_SRD;
        end
      end
      S_ORD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = IB'(j - 1'b1);
        state_next  = S_OLA;
      end
      S_OLA: begin
        cmd.ld_a    = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = j[IB-1:0];
        state_next  = S_OLB;
      end
      S_OLB: begin
        cmd.ld_b   = 1'b1;
        state_next = S_OCMP;
      end
      S_OCMP: begin
        if (sts.a_lt_b) begin
          cmd.wr_a    = 1'b1;
          cmd.wr_addr = j[IB-1:0];
          state_next  = S_OSW2;
        end else begin
          i_next = i + 1'b1;
          j_next = i + 1'b1;
          if (i + 1'b1 == used) begin
            i_next     = '0;
            state_next = S_RRD;
          end else begin
            state_next = S_ORD;
          end
        end
      end
      S_OSW2: begin
        cmd.wr_b    = 1'b1;
        cmd.wr_addr = IB'(j - 1'b1);
        if (j == UB'(1)) begin
          i_next = i + 1'b1;
          j_next = i + 1'b1;
          if (i + 1'b1 == used) begin
            i_next     = '0;
            state_next = S_RRD;
          end else begin
            state_next = S_ORD;
          end
        end else begin
          j_next     = j - 1'b1;
          state_next = S_ORD;
        end
      end
      S_RRD: begin
        if (used == '0) begin
          if (!out_busy || out_take) begin
            cmd.res_ld     = 1'b1;
            cmd.res_status = kftr_pkg::ST_EMPTY;
            cmd.res_src    = kftr_pkg::RS_ZERO;
            cmd.res_last   = 1'b1;
            out_set        = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = i[IB-1:0];
          state_next  = S_RLAT;
        end
      end
      S_RLAT: begin
        cmd.ld_b   = 1'b1;
        state_next = S_ROUT;
      end
      S_ROUT: begin
        if (!out_busy || out_take) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = kftr_pkg::ST_RANK;
          cmd.res_rank   = 6'(i + 1'b1);
          cmd.res_src    = kftr_pkg::RS_MEM;
          cmd.res_last   = (i + 1'b1 == used);
          out_set        = 1'b1;
          i_next         = i + 1'b1;
          state_next     = (i + 1'b1 == used) ? S_IDLE : S_RRD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/core/key_frequency_tally_and_rank_top.sv
// ---------------------------------------------------------------------------
// key_frequency_tally_and_rank_top
// Key occurrence tally with descending-count ranking report.
// ---------------------------------------------------------------------------
// One request at a time. A record walks the table one entry at a time
// (memory read, latch, compare). A report runs an insertion sort by
// adjacent swaps over the single-port table (read, latch A, latch B,
// compare, and a second write when it swaps; quadratic in the entry
// count), then reads out one ranked entry at a time. The result
// register lets the next request be accepted while the last result still
// waits.
module key_frequency_tally_and_rank_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // key
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], rank[8:3], hit_count[40:9], entry_key[104:41], zero[111:105]
  output logic [111:0] m_tdata,
  output logic         m_tlast
);

  kftr_pkg::kftr_cmd_t cmd;
  kftr_pkg::kftr_sts_t sts;
  logic        idle, out_set, in_fire, out_take;
  logic [2:0]  r_status;
  logic [5:0]  r_rank;
  logic [31:0] r_count;
  logic [63:0] r_key;

  assign s_tready = idle;
  assign in_fire  = s_tvalid && s_tready;
  assign out_take = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_set) m_tvalid <= 1'b1;
    else if (out_take) m_tvalid <= 1'b0;
  end

  kftr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .action   (s_tuser),
    .out_busy (m_tvalid),
    .out_take (out_take),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle),
    .out_set  (out_set)
  );

  kftr_datapath u_dp (
    .clk      (clk),
    .key_in   (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .r_status (r_status),
    .r_rank   (r_rank),
    .r_count  (r_count),
    .r_key    (r_key),
    .r_last   (m_tlast)
  );

  assign m_tdata = {7'd0, r_key, r_count, r_rank, r_status};

endmodule

>>> rtl/core/kftr_checker.sv
// ---------------------------------------------------------------------------
// kftr_checker
// Port-level checks on the tally block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kftr_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic         m_tlast
);

  logic [2:0] st;
  logic [5:0] rk;
  logic       stall, is_rank;

  assign st      = m_tdata[2:0];
  assign rk      = m_tdata[8:3];
  assign stall   = m_tvalid && !m_tready;
  assign is_rank = (st == kftr_pkg::ST_RANK);

  `CHK_IMPLY(a_hold, clk, rst, stall, ##1 m_tvalid && $stable(m_tdata), "stalled result changed")
  `CHK_IMPLY(a_rec_last, clk, rst, m_tvalid && !is_rank, m_tlast && rk == '0, "single result not last")
  `CHK_IMPLY(a_rank_nz, clk, rst, m_tvalid && is_rank, rk != '0, "ranking entry without rank")
  `CHK_ALWAYS(a_status, clk, rst, !m_tvalid || st <= kftr_pkg::ST_EMPTY, "status out of range")

endmodule

bind key_frequency_tally_and_rank_top kftr_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key tally and rank testbench
// Sends record and report requests to the tally table over the stream ports.
// Predicts every result with a local copy of the table, including the stable
// descending sort, and checks results in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  LIMIT     = 3000000;
  localparam bit  ACT_RECORD = 1'b0;
  localparam bit  ACT_REPORT = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  rank;
    logic [31:0] hits;
    logic [63:0] key;
    logic        last;
  } tally_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [63:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic         m_tlast;

  logic [63:0] tab_key [kftr_pkg::ENTRIES];
  logic [31:0] tab_cnt [kftr_pkg::ENTRIES];
  int          tab_used = 0;
  tally_res_t  pending_res [$];
  int          errors = 0;
  int          results_seen = 0;
  int          reports_sent = 0;
  int          drops_seen = 0;
  int          cycles = 0;
  logic [63:0] key_pool [40];

  key_frequency_tally_and_rank_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // expected results of one request, applied to the local table
  task automatic tally_predict(input bit act, input logic [63:0] k);
    tally_res_t r;
    logic [63:0] tk;
    logic [31:0] tc;
    int j;
    bit found;
    found = 0;
    r = '0;
    r.last = 1'b1;
    if (act == ACT_RECORD) begin
      for (int i = 0; i < tab_used && !found; i++)
        if (tab_key[i] == k) begin
          found = 1;
          if (tab_cnt[i] != 32'hFFFF_FFFF) tab_cnt[i] = tab_cnt[i] + 32'd1;
          r.status = kftr_pkg::ST_COUNTED;
          r.hits = tab_cnt[i];
          r.key = k;
        end
      if (!found) begin
        r.key = k;
        if (tab_used < kftr_pkg::ENTRIES) begin
          tab_key[tab_used] = k;
          tab_cnt[tab_used] = 32'd1;
          tab_used++;
          r.status = kftr_pkg::ST_NEW;
          r.hits = 32'd1;
        end else begin
          r.status = kftr_pkg::ST_DROPPED;
          drops_seen++;
        end
      end
      pending_res.push_back(r);
    end else if (tab_used == 0) begin
      r.status = kftr_pkg::ST_EMPTY;
      pending_res.push_back(r);
    end else begin
      for (int i = 1; i < tab_used; i++) begin
        tk = tab_key[i];
        tc = tab_cnt[i];
        j = i;
        while (j > 0 && tab_cnt[j-1] < tc) begin
          tab_key[j] = tab_key[j-1];
          tab_cnt[j] = tab_cnt[j-1];
          j--;
        end
        tab_key[j] = tk;
        tab_cnt[j] = tc;
      end
      for (int i = 0; i < tab_used; i++) begin
        r.status = kftr_pkg::ST_RANK;
        r.rank = 6'(i + 1);
        r.hits = tab_cnt[i];
        r.key = tab_key[i];
        r.last = (i + 1 == tab_used);
        pending_res.push_back(r);
      end
    end
  endtask

  task automatic send_request(input bit act, input logic [63:0] k);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = act;
    s_tdata = (act == ACT_REPORT && $urandom_range(0, 1)) ? {$urandom, $urandom} : k;
    // ready only changes at the rising edge, so its value here holds for the next one
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    tally_predict(act, s_tdata);
    if (act == ACT_REPORT) reports_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // result sink: random back-pressure
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    tally_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h last %b", m_tdata, m_tlast);
      end else begin
        want = pending_res.pop_front();
        if (m_tdata[2:0] !== want.status || m_tdata[8:3] !== want.rank ||
            m_tdata[40:9] !== want.hits || m_tdata[104:41] !== want.key ||
            m_tdata[111:105] !== 7'd0 || m_tlast !== want.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp st %0d rk %0d cnt %h key %h last %b",
                     want.status, want.rank, want.hits, want.key, want.last);
            $display("          got st %0d rk %0d cnt %h key %h last %b",
                     m_tdata[2:0], m_tdata[8:3], m_tdata[40:9], m_tdata[104:41], m_tlast);
          end
        end
      end
    end
  end

  task automatic test_empty_report();
    send_request(ACT_REPORT, '0);
  endtask

  task automatic test_extremes_and_ties();
    send_request(ACT_RECORD, 64'h0);
    send_request(ACT_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_RECORD, 64'h5555_5555_5555_5555);
    send_request(ACT_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ACT_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ACT_RECORD, 64'h0);
    send_request(ACT_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ACT_REPORT, '0);
    send_request(ACT_RECORD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_RECORD, 64'h5555_5555_5555_5555);
    send_request(ACT_REPORT, '0);
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 40; i++) key_pool[i] = {$urandom, $urandom};
    for (int n = 0; n < 230; n++) begin
      if ($urandom_range(0, 14) == 0)
        send_request(ACT_REPORT, '0);
      else if ($urandom_range(0, 9) == 0)
        send_request(ACT_RECORD, {$urandom, $urandom});
      else
        send_request(ACT_RECORD, key_pool[$urandom_range(0, 8 + n / 6 > 39 ? 39 : 8 + n / 6)]);
    end
  endtask

  task automatic test_full_table();
    int k;
    k = 0;
    while (tab_used < kftr_pkg::ENTRIES) begin
      send_request(ACT_RECORD, 64'h1000 + 64'(k));
      k++;
    end
    send_request(ACT_RECORD, 64'hDEAD_BEEF_0000_0001);
    send_request(ACT_RECORD, 64'h8000_0000_0000_0000);
    send_request(ACT_RECORD, tab_key[kftr_pkg::ENTRIES-1]);
    send_request(ACT_REPORT, '0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_report();
    test_extremes_and_ties();
    test_random_mix();
    test_full_table();
    while (pending_res.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d results checked, %0d reports, %0d dropped keys, table at %0d entries",
             results_seen, reports_sent, drops_seen, tab_used);
    $display("count saturation is not reachable in this run length");
    if (errors == 0 && pending_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/kftr_pkg.sv
rtl/core/kftr_datapath.sv
rtl/core/kftr_ctrl.sv
rtl/core/key_frequency_tally_and_rank_top.sv
rtl/core/kftr_checker.sv
tb/sv/testbench.sv
